[sv/detector_message_unpacker_unit_assert.svh]
// Assertion macros used by the checker file of the message unpacker.
`ifndef DETECTOR_MESSAGE_UNPACKER_UNIT_ASSERT_SVH
`define DETECTOR_MESSAGE_UNPACKER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define DMU_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dmu same-cycle check failed");

// Next-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define DMU_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dmu next-cycle check failed");

`endif

[sv/dmu_pkg.sv]
// Package with constants, types and record decoding of the message unpacker.
`timescale 1ns / 1ps

package dmu_pkg;

  // Bytes skipped at the start of every slice.
  localparam int unsigned HEADER_SKIP = 16;
  // Default number of epoch table entries.
  localparam int unsigned SOURCE_SLOTS_DEF = 16;

  // Message type codes in the low three bits of the last message byte.
  localparam logic [2:0] KIND_HIT   = 3'd1;
  localparam logic [2:0] KIND_EPOCH = 3'd2;
  localparam logic [2:0] KIND_SYNC  = 3'd3;

  // Record kind codes on the output.
  localparam logic REC_HIT  = 1'b0;
  localparam logic REC_SYNC = 1'b1;

  // A complete message as seen by the parser on its last byte.
  typedef struct packed {
    logic        valid;
    logic [7:0]  b5;
    logic [39:0] body;
    logic [15:0] src;
    logic [15:0] equip;
  } msg_evt_t;

  // Decoded record without its epoch.
  typedef struct packed {
    logic        record_kind;
    logic [15:0] equip_out;
    logic [17:0] source_channel;
    logic [6:0]  channel_number;
    logic [13:0] time_stamp;
    logic [11:0] adc_value;
    logic        last_epoch_flag;
    logic        pileup_flag;
    logic        overflow_flag;
    logic [1:0]  sync_status;
    logic [23:0] sync_data;
  } rec_t;

  function automatic rec_t decode_record(msg_evt_t evt);
    rec_t       rec;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
    logic [7:0] b4;
    logic [1:0] sub;
    b0  = evt.body[39:32];
    b1  = evt.body[31:24];
    b2  = evt.body[23:16];
    b3  = evt.body[15:8];
    b4  = evt.body[7:0];
    sub = evt.b5[7:6];
    rec = '0;
    rec.equip_out      = evt.equip;
    rec.source_channel = {evt.src, sub};
    if (evt.b5[2:0] == KIND_SYNC) begin
      rec.record_kind    = REC_SYNC;
      rec.channel_number = {5'd0, sub};
      rec.time_stamp     = {b3[5:0], b4};
      rec.sync_status    = b0[7:6];
      rec.sync_data      = {b0[5:0], b1, b2, b3[7:6]};
    end else begin
      rec.record_kind     = REC_HIT;
      rec.channel_number  = b2[7:1];
      rec.time_stamp      = {b2[0], b3, b4[7:3]};
      rec.adc_value       = {b0[4:0], b1[7:1]};
      rec.last_epoch_flag = b0[7];
      rec.pileup_flag     = b0[5];
      rec.overflow_flag   = b0[6];
    end
    return rec;
  endfunction

endpackage

[sv/dmu_in_if.sv]
// Input channel of the message unpacker: one slice byte per request.
`timescale 1ns / 1ps

interface dmu_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        slice_start;
  logic [15:0] equipment_id;

  modport source (output valid, data_byte, slice_start, equipment_id, input ready);
  modport sink (input valid, data_byte, slice_start, equipment_id, output ready);
endinterface

[sv/dmu_out_if.sv]
// Output channel of the message unpacker: one unpacked record per request.
`timescale 1ns / 1ps

interface dmu_out_if;
  logic        valid;
  logic        ready;
  logic        record_kind;
  logic [15:0] equip_out;
  logic [17:0] source_channel;
  logic [6:0]  channel_number;
  logic [31:0] epoch_value;
  logic [13:0] time_stamp;
  logic [11:0] adc_value;
  logic        last_epoch_flag;
  logic        pileup_flag;
  logic        overflow_flag;
  logic [1:0]  sync_status;
  logic [23:0] sync_data;

  modport source (
    output valid, record_kind, equip_out, source_channel, channel_number, epoch_value,
           time_stamp, adc_value, last_epoch_flag, pileup_flag, overflow_flag,
           sync_status, sync_data,
    input  ready
  );
  modport sink (
    input  valid, record_kind, equip_out, source_channel, channel_number, epoch_value,
           time_stamp, adc_value, last_epoch_flag, pileup_flag, overflow_flag,
           sync_status, sync_data,
    output ready
  );
endinterface

[sv/dmu_parser.sv]
// Byte-level slice parser: header skip, packet headers, messages and padding.
`timescale 1ns / 1ps

module dmu_parser import dmu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  logic [7:0]  byte_i,
  input  logic        start_i,
  input  logic [15:0] equip_i,
  output msg_evt_t    evt_o,
  output logic        msg_last_o
);

  typedef enum logic [1:0] {
    PhSkip,
    PhHead,
    PhMsg,
    PhPad
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [15:0] cnt_q, cnt_d;
  logic [9:0]  rem_q, rem_d;
  logic [2:0]  idx_q, idx_d;
  logic [15:0] src_q, src_d;
  logic [39:0] msg_q, msg_d;
  logic [15:0] off;
  logic [15:0] off_next;
  logic        pad_done;

  // The next byte completes a message unless a slice mark comes with it.
  assign msg_last_o = (phase_q == PhMsg) && (idx_q >= 3'd5);

  always_comb begin
    phase_d  = phase_q;
    rem_d    = rem_q;
    idx_d    = idx_q;
    src_d    = src_q;
    msg_d    = msg_q;
    off      = cnt_q;
    evt_o    = '0;

    // A slice mark drops whatever packet was in progress.
    if (start_i) begin
      phase_d = PhSkip;
      off     = '0;
      rem_d   = '0;
      idx_d   = '0;
    end
    if ((phase_d == PhSkip) && (off >= 16'(HEADER_SKIP))) begin
      phase_d = PhHead;
      idx_d   = '0;
    end

    off_next = off + 16'd1;
    pad_done = (off_next[2:0] == 3'd0);

    case (phase_d)
      PhHead: begin
        if (idx_d == 3'd0) begin
          rem_d = {1'b0, byte_i, 1'b0};
        end else if (idx_d == 3'd2) begin
          src_d[7:0] = byte_i;
        end else if (idx_d == 3'd3) begin
          src_d[15:8] = byte_i;
        end
        if (idx_d >= 3'd3) begin
          idx_d = '0;
          if (rem_d == '0) begin
            phase_d = pad_done ? PhHead : PhPad;
          end else begin
            phase_d = PhMsg;
          end
        end else begin
          idx_d = idx_d + 3'd1;
        end
      end
      PhMsg: begin
        if (idx_d >= 3'd5) begin
          evt_o.valid = step_i;
          evt_o.b5    = byte_i;
          evt_o.body  = msg_q;
          evt_o.src   = src_q;
          evt_o.equip = equip_i;
          idx_d       = '0;
        end else begin
          msg_d = {msg_q[31:0], byte_i};
          idx_d = idx_d + 3'd1;
        end
        // A partial message at the packet end is simply dropped here.
        rem_d = rem_d - 10'd1;
        if (rem_d == '0) begin
          idx_d   = '0;
          phase_d = pad_done ? PhHead : PhPad;
        end
      end
      PhPad: begin
        if (pad_done) begin
          phase_d = PhHead;
        end
        idx_d = '0;
      end
      default: begin
      end
    endcase

    cnt_d = off_next;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhSkip;
      cnt_q   <= '0;
      rem_q   <= '0;
      idx_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      rem_q   <= rem_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      src_q <= src_d;
      msg_q <= msg_d;
    end
  end

endmodule

[sv/detector_message_unpacker_unit.sv]
// Top level of the message unpacker: parser, epoch memory and record register.
`timescale 1ns / 1ps
// Throughput: one slice byte per cycle; while a finished record waits on the output,
//   only the byte that completes the next message is held until the record is taken.
// Record timing: a record is offered in the cycle after the last byte of its message is
//   accepted, through the registered read of the epoch memory.
// Reset: parser control and the output valid clear at once; then the epoch memory is
//   cleared one entry per cycle, all SOURCE_SLOTS of them, with the input ready held low.

module detector_message_unpacker_unit import dmu_pkg::*; #(
  parameter int unsigned SOURCE_SLOTS = SOURCE_SLOTS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  dmu_in_if.sink    req_i,
  dmu_out_if.source rec_o
);

  // The address is at least one bit wide so that a single-entry table still builds.
  localparam int unsigned AddrW = (SOURCE_SLOTS > 1) ? $clog2(SOURCE_SLOTS) : 1;

  msg_evt_t         evt;
  logic             msg_last;
  logic             step;
  logic             in_range;
  logic [AddrW-1:0] addr;
  logic             is_epoch;
  logic             is_rec;

  logic             clearing_q;
  logic [AddrW-1:0] clr_q;

  logic [31:0]      epoch_mem [SOURCE_SLOTS];
  logic [31:0]      rd_q;

  logic             out_valid_q;
  rec_t             rec_q;
  logic             in_range_q;

  // Only a byte that completes a message can load the record register, so only that
  // byte waits for the register to be free or drained. All other requests pass while
  // a record sits on the output.
  assign req_i.ready = !clearing_q && (!out_valid_q || rec_o.ready || !msg_last);
  assign step        = req_i.valid && req_i.ready;

  dmu_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .byte_i     (req_i.data_byte),
    .start_i    (req_i.slice_start),
    .equip_i    (req_i.equipment_id),
    .evt_o      (evt),
    .msg_last_o (msg_last)
  );

  // Sources beyond the table read epoch zero and never write it.
  assign in_range = ({1'b0, evt.src} < 17'(SOURCE_SLOTS));
  assign addr     = evt.src[AddrW-1:0];
  assign is_epoch = evt.valid && (evt.b5[2:0] == KIND_EPOCH);
  assign is_rec   = evt.valid && ((evt.b5[2:0] == KIND_HIT) || (evt.b5[2:0] == KIND_SYNC));

  // Epoch memory, one write port and one registered read port. An epoch update is
  // written on the last byte of its message; a hit or sync message of the same source
  // completes at least six accepted bytes later, so its read always sees the new value
  // and no forwarding path is needed.
  always_ff @(posedge clk_i) begin
    if (clearing_q) begin
      epoch_mem[clr_q] <= '0;
    end else if (is_epoch && in_range) begin
      epoch_mem[addr] <= evt.body[31:0];
    end
    if (is_rec) begin
      rd_q <= epoch_mem[addr];
    end
  end

  // Clearing pass after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_q      <= '0;
    end else if (clearing_q) begin
      if (clr_q == AddrW'(SOURCE_SLOTS - 1)) begin
        clearing_q <= 1'b0;
      end else begin
        clr_q <= clr_q + AddrW'(1);
      end
    end
  end

  // Record register. The memory read data is held in rd_q until the next record is
  // loaded, which only happens once this one has been taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (is_rec) begin
      out_valid_q <= 1'b1;
    end else if (rec_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_rec) begin
      rec_q      <= decode_record(evt);
      in_range_q <= in_range;
    end
  end

  assign rec_o.valid           = out_valid_q;
  assign rec_o.record_kind     = rec_q.record_kind;
  assign rec_o.equip_out       = rec_q.equip_out;
  assign rec_o.source_channel  = rec_q.source_channel;
  assign rec_o.channel_number  = rec_q.channel_number;
  assign rec_o.epoch_value     = in_range_q ? rd_q : 32'd0;
  assign rec_o.time_stamp      = rec_q.time_stamp;
  assign rec_o.adc_value       = rec_q.adc_value;
  assign rec_o.last_epoch_flag = rec_q.last_epoch_flag;
  assign rec_o.pileup_flag     = rec_q.pileup_flag;
  assign rec_o.overflow_flag   = rec_q.overflow_flag;
  assign rec_o.sync_status     = rec_q.sync_status;
  assign rec_o.sync_data       = rec_q.sync_data;

endmodule

[sv/dmu_checker.sv]
// Port-level checker of the message unpacker output, bound to the top level.
`timescale 1ns / 1ps
`include "detector_message_unpacker_unit_assert.svh"

module dmu_checker import dmu_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        valid_i,
  input logic        ready_i,
  input logic        record_kind_i,
  input logic [17:0] source_channel_i,
  input logic [6:0]  channel_number_i,
  input logic [31:0] epoch_value_i,
  input logic [13:0] time_stamp_i,
  input logic [11:0] adc_value_i,
  input logic        last_epoch_flag_i,
  input logic        pileup_flag_i,
  input logic        overflow_flag_i,
  input logic [1:0]  sync_status_i,
  input logic [23:0] sync_data_i
);

  `DMU_ASSERT_NEXT(a_valid_holds, valid_i && !ready_i, valid_i)
  `DMU_ASSERT_NEXT(a_payload_holds, valid_i && !ready_i, $stable(record_kind_i) && $stable(source_channel_i) && $stable(epoch_value_i) && $stable(time_stamp_i))
  `DMU_ASSERT_IMPL(a_sync_no_hit_fields, valid_i && (record_kind_i == REC_SYNC), (adc_value_i == 12'd0) && !last_epoch_flag_i && !pileup_flag_i && !overflow_flag_i)
  `DMU_ASSERT_IMPL(a_hit_no_sync_fields, valid_i && (record_kind_i == REC_HIT), (sync_status_i == 2'd0) && (sync_data_i == 24'd0))
  `DMU_ASSERT_IMPL(a_sync_channel, valid_i && (record_kind_i == REC_SYNC), (channel_number_i[6:2] == 5'd0) && (channel_number_i[1:0] == source_channel_i[1:0]))

endmodule

bind detector_message_unpacker_unit dmu_checker u_dmu_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .valid_i           (rec_o.valid),
  .ready_i           (rec_o.ready),
  .record_kind_i     (rec_o.record_kind),
  .source_channel_i  (rec_o.source_channel),
  .channel_number_i  (rec_o.channel_number),
  .epoch_value_i     (rec_o.epoch_value),
  .time_stamp_i      (rec_o.time_stamp),
  .adc_value_i       (rec_o.adc_value),
  .last_epoch_flag_i (rec_o.last_epoch_flag),
  .pileup_flag_i     (rec_o.pileup_flag),
  .overflow_flag_i   (rec_o.overflow_flag),
  .sync_status_i     (rec_o.sync_status),
  .sync_data_i       (rec_o.sync_data)
);

[tb/tb_detector_message_unpacker_unit.sv]
// Self-checking testbench of the detector message unpacker: slice stimulus, record predictor.
`timescale 1ns / 1ps

module tb_detector_message_unpacker_unit;
  import dmu_pkg::*;

  // The epoch table size is taken from the package so that the predictor and the
  // block agree on which sources have a table entry.
  localparam int unsigned SLOTS = SOURCE_SLOTS_DEF;

  // Generous bound on the run length in clock cycles. A correct run sends a few
  // thousand bytes at most, each after a random idle gap, plus a random sink
  // stall after every record.
  localparam int unsigned CYCLE_LIMIT = 500_000;

  // Parser phases, in the order a slice passes through them.
  typedef enum logic [1:0] {
    PH_SKIP,
    PH_HEAD,
    PH_MSG,
    PH_PAD
  } parse_phase_e;

  // One record as it leaves the block: the decoded fields plus the source epoch.
  typedef struct {
    rec_t        rec;
    logic [31:0] epoch;
  } record_t;

  // The checker keeps its own copy of the parser state and of the epoch table.
  // Every accepted byte is run through the same parse, and every hit or sync
  // message that completes leaves one expected record in the queue.
  class record_checker;
    parse_phase_e phase;
    logic [15:0]  byte_ofs;
    logic [9:0]   remaining;
    logic [15:0]  src_id;
    logic [39:0]  body;
    logic [2:0]   idx;
    logic [31:0]  epochs [SLOTS];
    record_t      expected_records [$];
    int           mismatches;
    int           records_seen;

    function new();
      phase        = PH_SKIP;
      byte_ofs     = '0;
      remaining    = '0;
      src_id       = '0;
      body         = '0;
      idx          = '0;
      mismatches   = 0;
      records_seen = 0;
      foreach (epochs[i]) epochs[i] = '0;
    endfunction

    function void report(string what);
      mismatches++;
      if (mismatches <= 10) $display("%s", what);
    endfunction

    // After the last byte of a packet: go straight to the next header when the
    // following byte sits on an 8-byte boundary, otherwise pad up to it.
    function void close_packet(logic [15:0] ofs);
      idx       = '0;
      remaining = '0;
      phase     = (ofs[2:0] == 3'd7) ? PH_HEAD : PH_PAD;
    endfunction

    // Completes a message on its sixth byte.
    function void finish_message(logic [7:0] b5, logic [15:0] equip);
      record_t    want;
      logic [7:0] b0;
      logic [7:0] b1;
      logic [7:0] b2;
      logic [7:0] b3;
      logic [7:0] b4;
      logic [1:0] sub;
      {b0, b1, b2, b3, b4} = body;
      sub = b5[7:6];
      if (b5[2:0] == KIND_EPOCH) begin
        // Updates for sources outside the table are dropped.
        if (src_id < SLOTS) epochs[src_id] = {b1, b2, b3, b4};
        return;
      end
      if (b5[2:0] != KIND_HIT && b5[2:0] != KIND_SYNC) return;
      want.rec                = '0;
      want.rec.equip_out      = equip;
      want.rec.source_channel = {src_id, sub};
      want.epoch              = (src_id < SLOTS) ? epochs[src_id] : 32'd0;
      if (b5[2:0] == KIND_HIT) begin
        want.rec.record_kind     = REC_HIT;
        want.rec.channel_number  = b2[7:1];
        want.rec.time_stamp      = {b2[0], b3, b4[7:3]};
        want.rec.adc_value       = {b0[4:0], b1[7:1]};
        want.rec.last_epoch_flag = b0[7];
        want.rec.pileup_flag     = b0[5];
        want.rec.overflow_flag   = b0[6];
      end else begin
        want.rec.record_kind    = REC_SYNC;
        want.rec.channel_number = {5'd0, sub};
        want.rec.time_stamp     = {b3[5:0], b4};
        want.rec.sync_status    = b0[7:6];
        want.rec.sync_data      = {b0[5:0], b1, b2, b3[7:6]};
      end
      expected_records.push_back(want);
    endfunction

    // Runs one accepted request through the parser.
    function void take_byte(logic [7:0] b, logic start, logic [15:0] equip);
      logic [15:0] ofs;
      if (start) begin
        byte_ofs  = '0;
        phase     = PH_SKIP;
        remaining = '0;
        idx       = '0;
      end
      ofs = byte_ofs;
      if (phase == PH_SKIP && ofs >= HEADER_SKIP) begin
        phase = PH_HEAD;
        idx   = '0;
      end
      case (phase)
        PH_HEAD: begin
          if (idx == 3'd0) remaining = {1'b0, b, 1'b0};
          else if (idx == 3'd2) src_id[7:0] = b;
          else if (idx == 3'd3) src_id[15:8] = b;
          if (idx >= 3'd3) begin
            idx  = '0;
            body = '0;
            if (remaining == '0) close_packet(ofs);
            else phase = PH_MSG;
          end else begin
            idx = idx + 3'd1;
          end
        end
        PH_MSG: begin
          if (idx >= 3'd5) begin
            finish_message(b, equip);
            idx  = '0;
            body = '0;
          end else begin
            body = {body[31:0], b};
            idx  = idx + 3'd1;
          end
          // A trailing part that cannot fill a message simply runs out here.
          remaining = remaining - 10'd1;
          if (remaining == '0) close_packet(ofs);
        end
        PH_PAD: begin
          if (ofs[2:0] == 3'd7) phase = PH_HEAD;
          idx = '0;
        end
        default: begin
        end
      endcase
      byte_ofs = ofs + 16'd1;
    endfunction

    function void compare(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want)
        report($sformatf("record %0d: %s expected 0x%0h, got 0x%0h",
                         records_seen, name, want, got));
    endfunction

    function void check_record(record_t got);
      record_t want;
      records_seen++;
      if (expected_records.size() == 0) begin
        report($sformatf("record %0d: unexpected record, kind %0b source_channel 0x%0h",
                         records_seen, got.rec.record_kind, got.rec.source_channel));
        return;
      end
      want = expected_records.pop_front();
      compare("record_kind", want.rec.record_kind, got.rec.record_kind);
      compare("equip_out", want.rec.equip_out, got.rec.equip_out);
      compare("source_channel", want.rec.source_channel, got.rec.source_channel);
      compare("channel_number", want.rec.channel_number, got.rec.channel_number);
      compare("epoch_value", want.epoch, got.epoch);
      compare("time_stamp", want.rec.time_stamp, got.rec.time_stamp);
      compare("adc_value", want.rec.adc_value, got.rec.adc_value);
      compare("last_epoch_flag", want.rec.last_epoch_flag, got.rec.last_epoch_flag);
      compare("pileup_flag", want.rec.pileup_flag, got.rec.pileup_flag);
      compare("overflow_flag", want.rec.overflow_flag, got.rec.overflow_flag);
      compare("sync_status", want.rec.sync_status, got.rec.sync_status);
      compare("sync_data", want.rec.sync_data, got.rec.sync_data);
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  dmu_in_if  in_if ();
  dmu_out_if out_if ();

  detector_message_unpacker_unit #(
    .SOURCE_SLOTS(SLOTS)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (in_if),
    .rec_o (out_if)
  );

  record_checker sb = new();

  // When set, both sides run without idle cycles.
  bit no_idle = 1'b0;
  // Offset of the next byte within the current slice, as the stimulus sees it.
  int slice_pos = 0;
  // Bytes sent inside packet headers and message areas.
  int parsed_bytes = 0;
  // Messages for the next packet, each one {b0, b1, b2, b3, b4, b5}.
  logic [47:0] pkt_msgs [$];
  int unsigned cycles = 0;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Watchdog. A hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_detector_message_unpacker_unit: errors");
      $finish;
    end
  end

  // Both channels are sampled on the rising edge, before the block's own updates
  // of that edge take effect. A record is offered at the earliest in the cycle after
  // the request that completed its message, so the order of the two checks is free.
  always @(posedge clk_i) begin : monitor
    record_t seen;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        seen.rec.record_kind     = out_if.record_kind;
        seen.rec.equip_out       = out_if.equip_out;
        seen.rec.source_channel  = out_if.source_channel;
        seen.rec.channel_number  = out_if.channel_number;
        seen.rec.time_stamp      = out_if.time_stamp;
        seen.rec.adc_value       = out_if.adc_value;
        seen.rec.last_epoch_flag = out_if.last_epoch_flag;
        seen.rec.pileup_flag     = out_if.pileup_flag;
        seen.rec.overflow_flag   = out_if.overflow_flag;
        seen.rec.sync_status     = out_if.sync_status;
        seen.rec.sync_data       = out_if.sync_data;
        seen.epoch               = out_if.epoch_value;
        sb.check_record(seen);
      end
      if (in_if.valid && in_if.ready)
        sb.take_byte(in_if.data_byte, in_if.slice_start, in_if.equipment_id);
    end
  end

  // Record sink. After every accepted record it draws a number of cycles with
  // ready low, so that stalls land on every phase of the parse.
  initial begin : record_sink
    int stall;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 16);
      repeat (stall) begin
        @(negedge clk_i);
        out_if.ready <= 1'b0;
      end
      @(negedge clk_i);
      out_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_if.valid) @(posedge clk_i);
    end
  end

  // Sends one byte after a random idle gap and waits until it is taken. The
  // equipment id changes on every byte, so a record shows which byte it was
  // sampled from.
  task automatic send_byte(logic [7:0] b, logic start);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 16);
    repeat (gap) begin
      @(negedge clk_i);
      in_if.valid <= 1'b0;
    end
    @(negedge clk_i);
    in_if.valid        <= 1'b1;
    in_if.data_byte    <= b;
    in_if.slice_start  <= start;
    in_if.equipment_id <= 16'($urandom);
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    slice_pos = start ? 1 : slice_pos + 1;
  endtask

  // The skipped part at the head of a slice. Without a mark the block must treat
  // the stream as a slice that has just begun.
  task automatic open_slice(logic marked);
    for (int i = 0; i < HEADER_SKIP; i++) send_byte(8'($urandom), marked && i == 0);
  endtask

  // Sends one packet built from pkt_msgs: header, a message area of 2*words
  // bytes (random filler once the messages run out) and padding to the next
  // 8-byte boundary. A cut of zero or more stops after that many bytes, which
  // leaves the packet unfinished for the next slice mark to drop.
  task automatic send_packet(logic [7:0] words, logic [15:0] src, int cut);
    logic [7:0]  head [4];
    logic [47:0] msg;
    logic [7:0]  b;
    int          total;
    int          i;
    head[0] = words;
    head[1] = 8'($urandom);
    head[2] = src[7:0];
    head[3] = src[15:8];
    total   = 4 + 2 * int'(words);
    for (i = 0; i < total && i != cut; i++) begin
      if (i < 4) begin
        b = head[i];
      end else if ((i - 4) / 6 < pkt_msgs.size()) begin
        msg = pkt_msgs[(i - 4) / 6];
        b   = msg[47 - 8 * ((i - 4) % 6) -: 8];
      end else begin
        b = 8'($urandom);
      end
      send_byte(b, 1'b0);
    end
    pkt_msgs.delete();
    parsed_bytes += i;
    if (i != cut)
      while (slice_pos % 8 != 0) send_byte(8'($urandom), 1'b0);
  endtask

  // Message bytes in stream order; the three middle bits of the last byte carry
  // nothing and are left random.
  function automatic logic [47:0] pack_msg(logic [39:0] msg_body, logic [1:0] sub,
                                           logic [2:0] kind);
    return {msg_body, sub, 3'($urandom), kind};
  endfunction

  // A marked slice of random packets, grown until it reaches min_len bytes.
  // Most packets hold whole messages; some end in a partial message, a few are
  // long, and with cut_pct percent a packet is broken off to end the slice.
  task automatic send_slice(int min_len, int cut_pct);
    int          r;
    int          words;
    int          cut;
    logic [15:0] src;
    logic [2:0]  kind;
    open_slice(1'b1);
    while (slice_pos < min_len) begin
      r = $urandom_range(0, 99);
      if (r < 70) words = 3 * $urandom_range(0, 4);
      else if (r < 92) words = $urandom_range(0, 12);
      else words = $urandom_range(13, 255);
      // Sources mostly hit the table so that epochs get written and read back.
      r = $urandom_range(0, 99);
      if (r < 75) src = 16'($urandom_range(0, SLOTS - 1));
      else if (r < 90) src = 16'($urandom_range(SLOTS, 255));
      else src = 16'($urandom);
      for (int k = 0; k < (2 * words + 5) / 6; k++) begin
        r = $urandom_range(0, 99);
        if (r < 30) begin
          kind = KIND_HIT;
        end else if (r < 55) begin
          kind = KIND_EPOCH;
        end else if (r < 80) begin
          kind = KIND_SYNC;
        end else begin
          do kind = 3'($urandom);
          while (kind == KIND_HIT || kind == KIND_EPOCH || kind == KIND_SYNC);
        end
        pkt_msgs.push_back(pack_msg({$urandom, 8'($urandom)}, 2'($urandom), kind));
      end
      cut = ($urandom_range(0, 99) < cut_pct) ? $urandom_range(1, 3 + 2 * words) : -1;
      send_packet(8'(words), src, cut);
      if (cut >= 0) break;
    end
  endtask

  initial begin
    int rec_goal;
    int len;
    rst_ni              = 1'b0;
    in_if.valid         = 1'b0;
    in_if.data_byte     = '0;
    in_if.slice_start   = 1'b0;
    in_if.equipment_id  = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part. The first packet arrives before any slice mark and sets
    // source 3 to the largest epoch, then carries an all-ones hit and sync.
    open_slice(1'b0);
    pkt_msgs.push_back(pack_msg({40{1'b1}}, 2'b00, KIND_EPOCH));
    pkt_msgs.push_back(pack_msg({40{1'b1}}, 2'b11, KIND_HIT));
    pkt_msgs.push_back(pack_msg({40{1'b1}}, 2'b11, KIND_SYNC));
    send_packet(8'd9, 16'd3, -1);

    // All-zero epoch, hit and sync on source 0.
    open_slice(1'b1);
    pkt_msgs.push_back(pack_msg('0, 2'b00, KIND_EPOCH));
    pkt_msgs.push_back(pack_msg('0, 2'b00, KIND_HIT));
    pkt_msgs.push_back(pack_msg('0, 2'b00, KIND_SYNC));
    send_packet(8'd9, 16'd0, -1);

    // Every message type other than hit, epoch and sync, all consumed without a record.
    for (int k = 0; k < 8; k++)
      if (k != KIND_HIT && k != KIND_EPOCH && k != KIND_SYNC)
        pkt_msgs.push_back(pack_msg({$urandom, 8'($urandom)}, 2'($urandom), 3'(k)));
    send_packet(8'd15, 16'd1, -1);

    // An empty packet goes straight to padding.
    send_packet(8'd0, 16'd2, -1);

    // Eight bytes of message area: one hit and a partial message that is dropped.
    pkt_msgs.push_back(pack_msg({$urandom, 8'($urandom)}, 2'($urandom), KIND_HIT));
    send_packet(8'd4, 16'd5, -1);

    // Sources just past the table and at the top of the range: the epoch update
    // is lost and the hit reads epoch zero.
    pkt_msgs.push_back(pack_msg({40{1'b1}}, 2'b01, KIND_EPOCH));
    pkt_msgs.push_back(pack_msg({$urandom, 8'($urandom)}, 2'b10, KIND_HIT));
    send_packet(8'd6, 16'(SLOTS), -1);
    pkt_msgs.push_back(pack_msg({40{1'b1}}, 2'b01, KIND_EPOCH));
    pkt_msgs.push_back(pack_msg({$urandom, 8'($urandom)}, 2'b11, KIND_SYNC));
    send_packet(8'd6, 16'hFFFF, -1);

    // A packet broken off inside its first message by a new slice mark; the
    // next slice then shows that source 3 kept its epoch.
    pkt_msgs.push_back(pack_msg({$urandom, 8'($urandom)}, 2'($urandom), KIND_HIT));
    pkt_msgs.push_back(pack_msg({$urandom, 8'($urandom)}, 2'($urandom), KIND_HIT));
    send_packet(8'd6, 16'd3, 7);
    open_slice(1'b1);
    pkt_msgs.push_back(pack_msg({$urandom, 8'($urandom)}, 2'($urandom), KIND_HIT));
    send_packet(8'd3, 16'd3, -1);

    // Random part: mostly well-formed slices with random content, some broken
    // off, and now and then a slice of plain noise. Idling is switched off for
    // whole slices at random.
    parsed_bytes = 0;
    rec_goal     = sb.records_seen + 30;
    while (parsed_bytes < 500 || sb.records_seen < rec_goal) begin
      no_idle = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 99) < 8) begin
        len = $urandom_range(8, 60);
        for (int i = 0; i < len; i++) send_byte(8'($urandom), i == 0);
      end else begin
        send_slice($urandom_range(40, 200), 5);
      end
    end
    no_idle = 1'b0;

    @(negedge clk_i);
    in_if.valid <= 1'b0;
    // Drain the outstanding records, then give the block time to show any
    // record it should not produce.
    while (sb.expected_records.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (sb.expected_records.size() != 0)
      sb.report($sformatf("%0d expected records never arrived",
                          sb.expected_records.size()));

    if (sb.mismatches == 0) begin
      $display("tb_detector_message_unpacker_unit: clean");
    end else begin
      $display("tb_detector_message_unpacker_unit: errors");
    end
    $finish;
  end

endmodule
